// ----- sv/dwps_pkg.sv -----
// shared constants and control types for the decayed window point smoother
package dwps_pkg;

   localparam int WINDOW_MAX_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT  = 16;

   localparam int COORD_W    = 16;
   localparam int DECAY_W    = 16;
   localparam int WLEN_W     = 5;
   localparam int ENTRY_W    = 2 * COORD_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd32768;
   localparam logic [WLEN_W-1:0]  WLEN_RESET  = 5'd16;

   // register word index, taken from paddr bit 2
   localparam logic REG_DECAY = 1'b0;
   localparam logic REG_WLEN  = 1'b1;

   typedef struct packed {
      logic latch;     // capture the input word
      logic write;     // update the ring with the captured point
      logic rd_start;  // load the oldest slot of the window
      logic rd_en;     // read one window entry and advance
      logic load_out;  // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic will_fill; // window holds a point once the update is done
      logic rd_last;   // current read is the newest entry
      logic out_free;  // output register can take a word this cycle
   } stat_type;

endpackage

// ----- sv/dwps_ram.sv -----
// generic single write port ram with registered read
module dwps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/dwps_ctrl.sv -----
// sequencing state machine: capture, ring update, window walk, result hand-off
module dwps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  dwps_pkg::stat_type stat,
   output dwps_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SETUP,
      ST_RUN,
      ST_LAST,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            // nothing to smooth while the window is still empty
            state_in  = stat.will_fill ? ST_SETUP : ST_DONE;
         end
         ST_SETUP: begin
            cmd.rd_start = 1'b1;
            state_in     = ST_RUN;
         end
         ST_RUN: begin
            cmd.rd_en = 1'b1;
            if (stat.rd_last) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            // last entry leaves the ram and goes into the accumulators
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/dwps_dp.sv -----
// datapath: point ring, fill tracking, two horner accumulators, output register
module dwps_dp #(
   parameter int WINDOW_MAX = dwps_pkg::WINDOW_MAX_DEFAULT,
   parameter int FRAC_BITS  = dwps_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dwps_pkg::cmd_type                    cmd,
   output dwps_pkg::stat_type                   stat,
   input  logic [dwps_pkg::COORD_W-1:0]         req_x,
   input  logic [dwps_pkg::COORD_W-1:0]         req_y,
   input  logic [dwps_pkg::DECAY_W-1:0]         decay,
   input  logic [dwps_pkg::WLEN_W-1:0]          wlen,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dwps_pkg::COORD_W-1:0]         rsp_x,
   output logic [dwps_pkg::COORD_W-1:0]         rsp_y,
   output logic                                 rsp_empty
);

   localparam int CW     = dwps_pkg::COORD_W;
   localparam int EW     = dwps_pkg::ENTRY_W;
   localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int ACC_W  = CW + FRAC_BITS;
   localparam int DIFF_W = ACC_W + 1;
   localparam int PROD_W = DIFF_W + dwps_pkg::DECAY_W + 1;
   localparam logic [CNT_W-1:0] WMAX_C    = CNT_W'(WINDOW_MAX);
   localparam logic [PTR_W-1:0] SLOT_LAST = PTR_W'(WINDOW_MAX - 1);

   logic [CW-1:0]    x_ff, y_ff;
   logic [PTR_W-1:0] ptr_ff, slot_ff;
   logic [CNT_W-1:0] wcnt_ff, k_ff;
   logic             filled_ff;
   logic [EW-1:0]    first_ff;
   logic             step_v_ff, step_first_ff, step_sel_ff;
   logic             out_valid_ff, out_empty_ff;
   logic [CW-1:0]    out_x_ff, out_y_ff;
   logic signed [ACC_W-1:0] acc_ff [2];
   logic signed [ACC_W-1:0] acc_in [2];

   logic              ok;
   logic [EW-1:0]     entry;
   logic [CNT_W-1:0]  n, n_last;
   logic [SUM_W-1:0]  start_sum;
   logic [PTR_W-1:0]  slot_start, slot_next;
   logic              written;
   logic              ram_wr_en;
   logic [EW-1:0]     rd_data;
   logic [CW-1:0]             pt [2];
   logic signed [DIFF_W-1:0]  diff [2];
   logic signed [PROD_W-1:0]  prod [2];

   assign ok    = ~x_ff[CW-1] & (|x_ff) & ~y_ff[CW-1] & (|y_ff);
   assign entry = {y_ff, x_ff};

   // out of range window lengths clamp to 1 .. WINDOW_MAX
   always_comb begin
      if (wlen == '0) begin
         n = CNT_W'(1);
      end else if (32'(wlen) > WINDOW_MAX) begin
         n = WMAX_C;
      end else begin
         n = CNT_W'(wlen);
      end
   end

   assign n_last = n - CNT_W'(1);

   // oldest slot of the window, ptr - n modulo the ring size
   always_comb begin
      if (SUM_W'(ptr_ff) >= SUM_W'(n)) begin
         start_sum = SUM_W'(ptr_ff) - SUM_W'(n);
      end else begin
         start_sum = SUM_W'(ptr_ff) + SUM_W'(WMAX_C) - SUM_W'(n);
      end
   end

   assign slot_start = start_sum[PTR_W-1:0];
   assign slot_next  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + PTR_W'(1);

   // slots past the write count still hold the first point
   assign written = (wcnt_ff == WMAX_C) || (SUM_W'(slot_ff) < SUM_W'(wcnt_ff));

   assign ram_wr_en = cmd.write & ok & filled_ff;

   dwps_ram #(
      .WIDTH (EW),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         pt[c]   = step_sel_ff ? first_ff[c*CW +: CW] : rd_data[c*CW +: CW];
         diff[c] = $signed({1'b0, pt[c], {FRAC_BITS{1'b0}}}) - {acc_ff[c][ACC_W-1], acc_ff[c]};
         prod[c] = PROD_W'($signed({1'b0, decay})) * PROD_W'(diff[c]);
         if (step_first_ff) begin
            acc_in[c] = $signed({pt[c], {FRAC_BITS{1'b0}}});
         end else begin
            // arithmetic shift by 16 floors the step
            acc_in[c] = acc_ff[c] + $signed(prod[c][ACC_W+15:16]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         x_ff <= req_x;
         y_ff <= req_y;
      end
      if (cmd.write && ok && !filled_ff) begin
         first_ff <= entry;
      end
      if (cmd.rd_start) begin
         slot_ff <= slot_start;
         k_ff    <= '0;
      end else if (cmd.rd_en) begin
         slot_ff <= slot_next;
         k_ff    <= k_ff + CNT_W'(1);
      end
      step_first_ff <= (k_ff == '0);
      step_sel_ff   <= ~written;
      if (step_v_ff) begin
         acc_ff[0] <= acc_in[0];
         acc_ff[1] <= acc_in[1];
      end
      if (cmd.load_out) begin
         out_x_ff     <= filled_ff ? acc_ff[0][FRAC_BITS +: CW] : '0;
         out_y_ff     <= filled_ff ? acc_ff[1][FRAC_BITS +: CW] : '0;
         out_empty_ff <= ~filled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         wcnt_ff      <= '0;
         filled_ff    <= 1'b0;
         step_v_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_v_ff <= cmd.rd_en;
         if (cmd.write && ok) begin
            if (!filled_ff) begin
               filled_ff <= 1'b1;
            end else begin
               ptr_ff <= (ptr_ff == SLOT_LAST) ? '0 : ptr_ff + PTR_W'(1);
               if (wcnt_ff != WMAX_C) begin
                  wcnt_ff <= wcnt_ff + CNT_W'(1);
               end
            end
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.will_fill = filled_ff | ok;
   assign stat.rd_last   = (k_ff == n_last);
   assign stat.out_free  = ~out_valid_ff | rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_x     = out_x_ff;
   assign rsp_y     = out_y_ff;
   assign rsp_empty = out_empty_ff;

endmodule

// ----- sv/decayed_window_point_smoother_core.sv -----
// top level: csr registers, controller and datapath of the point smoother
//
//  port group | dir | payload
//  req_*      | in  | tdata: point_x[15:0], point_y[31:16]
//  rsp_*      | out | tdata: smoothed_x[15:0], smoothed_y[31:16]; tuser: window_empty
//  csr_*      | in  | decay at 0x0, window_length at 0x4
//
// once the window holds a point, every word, a rejected point's included, is offered
// after a walk over the newest ring entries, as many as the clamped window length:
// one ring entry is read and folded into both accumulators per cycle through a single ram read port.
// a point that leaves the window empty skips the walk over the window.
// the next point can be taken in the cycle after the word is loaded.
// a new point is taken while the previous word waits in the output register; a second
// finished word holds the sequencer until the output register is free.
// reset is synchronous; no clearing pass, the first valid point seeds the ring.
module decayed_window_point_smoother_core #(
   parameter int WINDOW_MAX = dwps_pkg::WINDOW_MAX_DEFAULT,
   parameter int FRAC_BITS  = dwps_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // point_x, point_y
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // smoothed_x, smoothed_y
   output logic                              rsp_tuser,   // window_empty
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dwps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dwps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dwps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [dwps_pkg::DECAY_W-1:0] decay_ff;
   logic [dwps_pkg::WLEN_W-1:0]  wlen_ff;
   logic                         csr_wr;
   dwps_pkg::cmd_type            cmd;
   dwps_pkg::stat_type           stat;
   logic [dwps_pkg::COORD_W-1:0] rsp_x, rsp_y;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= dwps_pkg::DECAY_RESET;
         wlen_ff  <= dwps_pkg::WLEN_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            dwps_pkg::REG_DECAY: decay_ff <= csr_pwdata[dwps_pkg::DECAY_W-1:0];
            dwps_pkg::REG_WLEN:  wlen_ff  <= csr_pwdata[dwps_pkg::WLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         dwps_pkg::REG_DECAY: csr_prdata = dwps_pkg::CSR_DATA_W'(decay_ff);
         dwps_pkg::REG_WLEN:  csr_prdata = dwps_pkg::CSR_DATA_W'(wlen_ff);
         default:             csr_prdata = '0;
      endcase
   end

   dwps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dwps_dp #(
      .WINDOW_MAX (WINDOW_MAX),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_x     (req_tdata[15:0]),
      .req_y     (req_tdata[31:16]),
      .decay     (decay_ff),
      .wlen      (wlen_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_x     (rsp_x),
      .rsp_y     (rsp_y),
      .rsp_empty (rsp_tuser)
   );

   assign rsp_tdata = {rsp_y, rsp_x};

`ifndef SYNTHESIS
   // an empty window reports the origin
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("empty window word with nonzero coordinates");

   // the weighted mean never leaves the range of accepted points, all positive
   a_mean_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         $signed(rsp_tdata[15:0]) > 16'sd0 && $signed(rsp_tdata[31:16]) > 16'sd0)
      else $error("smoothed point outside the positive quadrant");

   // one point at a time through the sequencer
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted while a point is in progress");
`endif

endmodule

// ----- dv/tb.sv -----
// testbench for the decayed window point smoother: directed table, random phases, scoreboard
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int SETTLE_CYCLES = dwps_pkg::WINDOW_MAX_DEFAULT + 12;
   localparam int PHASE_ITEMS = 230;
   localparam int NUM_PHASES = 8;

   typedef enum logic [1:0] {ROW_POINT, ROW_DECAY, ROW_WLEN} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0] a;       // point_x, or register value
      logic [15:0] b;       // point_y
      logic        known;   // expected word typed in below
      logic [15:0] ex;
      logic [15:0] ey;
      logic        ee;
   } dir_row_type;

   typedef struct packed {
      logic [15:0] sx;
      logic [15:0] sy;
      logic        empty;
   } smooth_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [31:0] req_tdata;   // point_x[15:0], point_y[31:16]
   logic rsp_tvalid;
   logic rsp_tready;
   logic [31:0] rsp_tdata;   // smoothed_x[15:0], smoothed_y[31:16]
   logic rsp_tuser;          // window_empty
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [dwps_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [dwps_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [dwps_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   decayed_window_point_smoother_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block state
   logic [31:0] ring [dwps_pkg::WINDOW_MAX_DEFAULT];
   logic [3:0] write_slot;
   logic seeded;
   logic [dwps_pkg::DECAY_W-1:0] decay_q16;
   logic [dwps_pkg::WLEN_W-1:0] wlen_reg;

   smooth_type pending_smooth [$];
   int mismatch_count = 0;
   int words_taken = 0;
   int cycle_count = 0;
   int burst_left = 0;

   // horner fold of one coordinate, oldest to newest
   function automatic logic [15:0] weighted_coord(input int n, input int sh);
      int slot;
      longint acc;
      longint pt;
      longint diff;
      slot = (int'(write_slot) + dwps_pkg::WINDOW_MAX_DEFAULT - n)
             % dwps_pkg::WINDOW_MAX_DEFAULT;
      acc = longint'((ring[slot] >> sh) & 32'hFFFF) <<< dwps_pkg::FRAC_BITS_DEFAULT;
      for (int i = 1; i < n; i++) begin
         slot = (slot + 1) % dwps_pkg::WINDOW_MAX_DEFAULT;
         pt = longint'((ring[slot] >> sh) & 32'hFFFF) <<< dwps_pkg::FRAC_BITS_DEFAULT;
         diff = pt - acc;
         acc += (longint'(decay_q16) * diff) >>> 16;
      end
      if (acc < 0) acc = 0;
      return acc[dwps_pkg::FRAC_BITS_DEFAULT +: 16];
   endfunction

   function automatic smooth_type advance_window(input logic [15:0] px,
                                                 input logic [15:0] py);
      smooth_type r;
      int n;
      if (!px[15] && px != 0 && !py[15] && py != 0) begin
         if (!seeded) begin
            for (int i = 0; i < dwps_pkg::WINDOW_MAX_DEFAULT; i++) ring[i] = {py, px};
            seeded = 1'b1;
         end else begin
            ring[write_slot] = {py, px};
            write_slot = write_slot + 4'd1;
         end
      end
      if (!seeded) begin
         r = '{sx: 16'd0, sy: 16'd0, empty: 1'b1};
      end else begin
         n = int'(wlen_reg);
         if (n < 1) n = 1;
         if (n > dwps_pkg::WINDOW_MAX_DEFAULT) n = dwps_pkg::WINDOW_MAX_DEFAULT;
         r.sx = weighted_coord(n, 0);
         r.sy = weighted_coord(n, 16);
         r.empty = 1'b0;
      end
      return r;
   endfunction

   task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                             input logic known, input smooth_type typed);
      smooth_type predicted;
      req_tvalid <= 1'b1;
      req_tdata <= {py, px};
      do @(posedge clock); while (!req_tready);
      predicted = advance_window(px, py);
      pending_smooth.insert(pending_smooth.size(), known ? typed : predicted);
   endtask

   // bursts of random length with random gaps, some stretches back to back
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (pending_smooth.size() != 0) @(posedge clock);
      // rejected points are answered too, so an empty queue shows the block is done; let it settle
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == dwps_pkg::REG_DECAY) decay_q16 = value[dwps_pkg::DECAY_W-1:0];
      else wlen_reg = value[dwps_pkg::WLEN_W-1:0];
   endtask

   // result side: stall pattern, one long hold, and the scoreboard
   initial begin
      int mode;
      int mode_left;
      int tick;
      int hold_left;
      logic held;
      smooth_type want;
      mode = 0;
      mode_left = 0;
      tick = 0;
      hold_left = 0;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            words_taken++;
            if (pending_smooth.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected word x=%0d y=%0d empty=%0b", $realtime,
                        $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]), rsp_tuser);
            end else begin
               want = pending_smooth.pop_front();
               if (rsp_tdata[15:0] !== want.sx) begin
                  mismatch_count++;
                  $display("%0t: smoothed_x expected %0d actual %0d", $realtime,
                           $signed(want.sx), $signed(rsp_tdata[15:0]));
               end
               if (rsp_tdata[31:16] !== want.sy) begin
                  mismatch_count++;
                  $display("%0t: smoothed_y expected %0d actual %0d", $realtime,
                           $signed(want.sy), $signed(rsp_tdata[31:16]));
               end
               if (rsp_tuser !== want.empty) begin
                  mismatch_count++;
                  $display("%0t: window_empty expected %0b actual %0b", $realtime,
                           want.empty, rsp_tuser);
               end
            end
         end
         if (!held && words_taken == 400) begin
            held = 1'b1;
            hold_left = 500;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 160);
         end
         mode_left--;
         tick++;
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (tick % 4 == 0);
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("decayed_window_point_smoother_core test failed");
         $finish;
      end
   end

   initial begin
      dir_row_type rows [25];
      logic [31:0] value;
      logic [15:0] px;
      logic [15:0] py;
      rows = '{
         '{ROW_POINT, 16'd0, 16'd0, 1'b1, 16'd0, 16'd0, 1'b1},
         '{ROW_POINT, 16'h8000, 16'd100, 1'b1, 16'd0, 16'd0, 1'b1},
         '{ROW_POINT, 16'd100, 16'h8000, 1'b1, 16'd0, 16'd0, 1'b1},
         '{ROW_POINT, 16'd1, 16'd0, 1'b1, 16'd0, 16'd0, 1'b1},
         '{ROW_POINT, 16'd32767, 16'hFFFF, 1'b1, 16'd0, 16'd0, 1'b1},
         // first valid point seeds the whole ring
         '{ROW_POINT, 16'd32767, 16'd32767, 1'b1, 16'd32767, 16'd32767, 1'b0},
         '{ROW_POINT, 16'd0, 16'd5, 1'b1, 16'd32767, 16'd32767, 1'b0},
         '{ROW_POINT, 16'd1, 16'd1, 1'b1, 16'd16384, 16'd16384, 1'b0},
         '{ROW_POINT, 16'd32767, 16'd1, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_POINT, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_WLEN, 16'd1, 16'd0, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_POINT, 16'd123, 16'd4567, 1'b1, 16'd123, 16'd4567, 1'b0},
         '{ROW_POINT, 16'hFFFB, 16'd9, 1'b1, 16'd123, 16'd4567, 1'b0},
         // zero length acts as one
         '{ROW_WLEN, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_POINT, 16'd32767, 16'd1, 1'b1, 16'd32767, 16'd1, 1'b0},
         '{ROW_WLEN, 16'd31, 16'd0, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_POINT, 16'd2, 16'd32767, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_DECAY, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_POINT, 16'd77, 16'd88, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_WLEN, 16'd2, 16'd0, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_POINT, 16'd500, 16'd600, 1'b0, 16'd0, 16'd0, 1'b0},
         // zero decay keeps only the oldest of the two
         '{ROW_POINT, 16'd700, 16'd800, 1'b1, 16'd500, 16'd600, 1'b0},
         '{ROW_DECAY, 16'hFFFF, 16'd0, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_POINT, 16'd1000, 16'd2000, 1'b0, 16'd0, 16'd0, 1'b0},
         '{ROW_POINT, 16'd32767, 16'd32767, 1'b0, 16'd0, 16'd0, 1'b0}
      };

      for (int i = 0; i < dwps_pkg::WINDOW_MAX_DEFAULT; i++) ring[i] = '0;
      write_slot = '0;
      seeded = 1'b0;
      decay_q16 = dwps_pkg::DECAY_RESET;
      wlen_reg = dwps_pkg::WLEN_RESET;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         case (rows[i].kind)
            ROW_DECAY: write_reg(dwps_pkg::REG_DECAY, {16'd0, rows[i].a});
            ROW_WLEN: write_reg(dwps_pkg::REG_WLEN, {16'd0, rows[i].a});
            default: begin
               send_point(rows[i].a, rows[i].b, rows[i].known,
                          '{sx: rows[i].ex, sy: rows[i].ey, empty: rows[i].ee});
               pace();
            end
         endcase
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: value = {16'd0, dwps_pkg::DECAY_RESET};
            1: value = 32'd0;
            2: value = 32'h0000_FFFF;
            3: value = 32'd1;
            default: value = $urandom_range(0, 65535);
         endcase
         write_reg(dwps_pkg::REG_DECAY, value);
         case (ph)
            0: value = 32'd16;
            1: value = 32'd31;
            2: value = 32'd0;
            3: value = 32'd1;
            default: value = $urandom_range(0, 31);
         endcase
         write_reg(dwps_pkg::REG_WLEN, value);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 85) begin
               // well-formed point, with the coordinate extremes now and then
               case ($urandom_range(0, 7))
                  0: px = 16'd1;
                  1: px = 16'd32767;
                  default: px = 16'($urandom_range(1, 32767));
               endcase
               case ($urandom_range(0, 7))
                  0: py = 16'd1;
                  1: py = 16'd32767;
                  default: py = 16'($urandom_range(1, 32767));
               endcase
            end else begin
               px = 16'($urandom);
               py = 16'($urandom);
            end
            send_point(px, py, 1'b0, '0);
            pace();
         end
      end

      req_tvalid <= 1'b0;
      while (pending_smooth.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_smooth.size() == 0) begin
         $display("decayed_window_point_smoother_core test passed");
      end else begin
         $display("decayed_window_point_smoother_core test failed");
      end
      $finish;
   end

endmodule

// ----- decayed_window_point_smoother_core.f -----
sv/dwps_pkg.sv
sv/dwps_ram.sv
sv/dwps_ctrl.sv
sv/dwps_dp.sv
sv/decayed_window_point_smoother_core.sv
dv/tb.sv
